// File: hdl/pcpg_pkg.sv
// shared types, constants and a helper function for the placement guide
`default_nettype none
package pcpg_pkg;

	// sensors taken into the centroid, 3 to 8
	localparam int SENSOR_COUNT = 8;
	localparam int IDX_W = 3;
	localparam int CNT_W = 4;

	// sensor positions, q6.8 mm, x = r*sin, y = r*cos, clockwise from top
	localparam logic signed [14:0] POS_X [8] = '{
		15'sd0, 15'sd5604, 15'sd7996, 15'sd5308,
		15'sd0, -15'sd5476, -15'sd7750, -15'sd6324
	};
	localparam logic signed [14:0] POS_Y [8] = '{
		15'sd7680, 15'sd5604, 15'sd140, -15'sd5497,
		-15'sd7680, -15'sd5476, -15'sd135, 15'sd4765
	};

	typedef enum logic [2:0] {
		REG_DEADBAND = 3'd0,
		REG_ALPHA    = 3'd1,
		REG_ENTER    = 3'd2,
		REG_EXIT     = 3'd3,
		REG_OK       = 3'd4,
		REG_MILD     = 3'd5,
		REG_MODERATE = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PR_OK         = 4'd0,
		PR_LEFT       = 4'd1,
		PR_RIGHT      = 4'd2,
		PR_UP         = 4'd3,
		PR_DOWN       = 4'd4,
		PR_UP_LEFT    = 4'd5,
		PR_UP_RIGHT   = 4'd6,
		PR_DOWN_LEFT  = 4'd7,
		PR_DOWN_RIGHT = 4'd8
	} prompt_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ACC,
		OP_DIV_CX,
		OP_DIV_CY,
		OP_DIV_SEV,
		OP_DIV_EFF,
		OP_DIV_STEP,
		OP_SAVE_CX,
		OP_SAVE_CY,
		OP_FILT_MUL,
		OP_FILT_ADD,
		OP_SQ_MUL,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_ROUND,
		OP_SEG,
		OP_SAVE_SEV,
		OP_SAVE_EFF,
		OP_COMMIT,
		OP_COMMIT_ZERO
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ACC,
		ST_CHECK,
		ST_DIVX_INIT,
		ST_DIVX,
		ST_SAVEX,
		ST_DIVY_INIT,
		ST_DIVY,
		ST_SAVEY,
		ST_FMUL,
		ST_FADD,
		ST_SQMUL,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_ROUND,
		ST_SEG,
		ST_DSEV_INIT,
		ST_DSEV,
		ST_SAVE_SEV,
		ST_DEFF_INIT,
		ST_DEFF,
		ST_SAVE_EFF,
		ST_COMMIT,
		ST_ZERO
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic sum_zero;
		logic seg_div;
		logic out_free;
	} status_t;

	// direction prompt for a filtered centroid beyond the enter threshold
	function automatic prompt_t direction(logic signed [15:0] x, logic signed [15:0] y,
			logic [14:0] thr);
		logic signed [16:0] t;
		logic xh, xl, yh, yl;
		prompt_t p;
		t = $signed({2'b00, thr});
		xh = 17'(x) > t;
		xl = 17'(x) < -t;
		yh = 17'(y) > t;
		yl = 17'(y) < -t;
		if (!xh && !xl && !yh && !yl) p = PR_OK;
		else if (yl && xl) p = PR_UP_RIGHT;
		else if (yl && xh) p = PR_UP_LEFT;
		else if (yh && xl) p = PR_DOWN_RIGHT;
		else if (yh && xh) p = PR_DOWN_LEFT;
		else if (xh) p = PR_LEFT;
		else if (xl) p = PR_RIGHT;
		else if (yh) p = PR_DOWN;
		else p = PR_UP;
		return p;
	endfunction

endpackage
`default_nettype wire

// File: hdl/pcpg_ctrl.sv
// controller state machine sequencing the placement guide datapath
`default_nettype none
module pcpg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output pcpg_pkg::cmd_t    cmd,
	input  pcpg_pkg::status_t status
);
	import pcpg_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic last_iter;
	logic last_sensor;

	assign last_iter = (cnt_q == CNT_W'(15));
	assign last_sensor = (cnt_q == CNT_W'(SENSOR_COUNT - 1));

	// state and iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_ACC;
			ST_ACC:       if (last_sensor) state_d = ST_CHECK;
			ST_CHECK:     state_d = status.sum_zero ? ST_ZERO : ST_DIVX_INIT;
			ST_DIVX_INIT: state_d = ST_DIVX;
			ST_DIVX:      if (last_iter) state_d = ST_SAVEX;
			ST_SAVEX:     state_d = ST_DIVY_INIT;
			ST_DIVY_INIT: state_d = ST_DIVY;
			ST_DIVY:      if (last_iter) state_d = ST_SAVEY;
			ST_SAVEY:     state_d = ST_FMUL;
			ST_FMUL:      state_d = ST_FADD;
			ST_FADD:      state_d = ST_SQMUL;
			ST_SQMUL:     state_d = ST_SQRT_INIT;
			ST_SQRT_INIT: state_d = ST_SQRT;
			ST_SQRT:      if (last_iter) state_d = ST_ROUND;
			ST_ROUND:     state_d = ST_SEG;
			ST_SEG:       state_d = status.seg_div ? ST_DSEV_INIT : ST_COMMIT;
			ST_DSEV_INIT: state_d = ST_DSEV;
			ST_DSEV:      if (last_iter) state_d = ST_SAVE_SEV;
			ST_SAVE_SEV:  state_d = ST_DEFF_INIT;
			ST_DEFF_INIT: state_d = ST_DEFF;
			ST_DEFF:      if (last_iter) state_d = ST_SAVE_EFF;
			ST_SAVE_EFF:  state_d = ST_COMMIT;
			ST_COMMIT:    if (status.out_free) state_d = ST_IDLE;
			ST_ZERO:      if (status.out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op = OP_NONE;
		cmd.idx = cnt_q[IDX_W-1:0];
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_ACC:       cmd.op = OP_ACC;
			ST_CHECK:     cmd.op = OP_NONE;
			ST_DIVX_INIT: cmd.op = OP_DIV_CX;
			ST_DIVX:      cmd.op = OP_DIV_STEP;
			ST_SAVEX:     cmd.op = OP_SAVE_CX;
			ST_DIVY_INIT: cmd.op = OP_DIV_CY;
			ST_DIVY:      cmd.op = OP_DIV_STEP;
			ST_SAVEY:     cmd.op = OP_SAVE_CY;
			ST_FMUL:      cmd.op = OP_FILT_MUL;
			ST_FADD:      cmd.op = OP_FILT_ADD;
			ST_SQMUL:     cmd.op = OP_SQ_MUL;
			ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
			ST_SQRT:      cmd.op = OP_SQRT_STEP;
			ST_ROUND:     cmd.op = OP_ROUND;
			ST_SEG:       cmd.op = OP_SEG;
			ST_DSEV_INIT: cmd.op = OP_DIV_SEV;
			ST_DSEV:      cmd.op = OP_DIV_STEP;
			ST_SAVE_SEV:  cmd.op = OP_SAVE_SEV;
			ST_DEFF_INIT: cmd.op = OP_DIV_EFF;
			ST_DEFF:      cmd.op = OP_DIV_STEP;
			ST_SAVE_EFF:  cmd.op = OP_SAVE_EFF;
			ST_COMMIT:    if (status.out_free) cmd.op = OP_COMMIT;
			ST_ZERO:      if (status.out_free) cmd.op = OP_COMMIT_ZERO;
			default:      cmd.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/pcpg_datapath.sv
// datapath: config registers, accumulator, shared divider, filter, square root, output register
`default_nettype none
module pcpg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  pcpg_pkg::cmd_t      cmd,
	output pcpg_pkg::status_t   status,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic signed [15:0]  sensor_0,
	input  logic signed [15:0]  sensor_1,
	input  logic signed [15:0]  sensor_2,
	input  logic signed [15:0]  sensor_3,
	input  logic signed [15:0]  sensor_4,
	input  logic signed [15:0]  sensor_5,
	input  logic signed [15:0]  sensor_6,
	input  logic signed [15:0]  sensor_7,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [17:0]         total_activity,
	output logic signed [15:0]  raw_x,
	output logic signed [15:0]  raw_y,
	output logic signed [15:0]  filtered_x,
	output logic signed [15:0]  filtered_y,
	output logic [15:0]         offset,
	output logic [15:0]         severity,
	output logic [15:0]         effectiveness,
	output logic [3:0]          prompt,
	output logic                correcting
);
	import pcpg_pkg::*;

	// configuration registers
	logic [14:0] deadband_q;
	logic [15:0] alpha_q;
	logic [14:0] enter_q;
	logic [14:0] exit_q;
	logic [15:0] ok_q;
	logic [15:0] mild_q;
	logic [15:0] moderate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= 15'd0;
			alpha_q <= 16'd8192;
			enter_q <= 15'd2560;
			exit_q <= 15'd1536;
			ok_q <= 16'd1280;
			mild_q <= 16'd2560;
			moderate_q <= 16'd5120;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEADBAND: deadband_q <= cfg_data[14:0];
				REG_ALPHA:    alpha_q <= cfg_data;
				REG_ENTER:    enter_q <= cfg_data[14:0];
				REG_EXIT:     exit_q <= cfg_data[14:0];
				REG_OK:       ok_q <= cfg_data;
				REG_MILD:     mild_q <= cfg_data;
				REG_MODERATE: moderate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// qualified samples: negative or below deadband count as zero
	logic signed [15:0] sens [8];
	logic [14:0] qual [8];
	logic [14:0] samp_q [8];

	assign sens[0] = sensor_0;
	assign sens[1] = sensor_1;
	assign sens[2] = sensor_2;
	assign sens[3] = sensor_3;
	assign sens[4] = sensor_4;
	assign sens[5] = sensor_5;
	assign sens[6] = sensor_6;
	assign sens[7] = sensor_7;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (sens[i][15] || (sens[i][14:0] < deadband_q)) qual[i] = '0;
			else qual[i] = sens[i][14:0];
		end
	end

	// accumulator: one sensor per cycle
	logic [14:0] acc_a;
	logic signed [30:0] acc_px, acc_py;
	logic [17:0] sum_q;
	logic signed [32:0] tx_q, ty_q;

	assign acc_a = samp_q[cmd.idx];
	assign acc_px = $signed({1'b0, acc_a}) * POS_X[cmd.idx];
	assign acc_py = $signed({1'b0, acc_a}) * POS_Y[cmd.idx];

	// shared divider operand select
	logic [31:0] mag_x, mag_y;
	logic [39:0] div_num;
	logic [24:0] div_den;
	logic div_neg;
	logic [39:0] sevn_q, effn_q;
	logic [24:0] sevd_q, effd_q;

	assign mag_x = tx_q[32] ? 32'(-tx_q) : 32'(tx_q);
	assign mag_y = ty_q[32] ? 32'(-ty_q) : 32'(ty_q);

	always_comb begin
		div_num = '0;
		div_den = '0;
		div_neg = 1'b0;
		case (cmd.op)
			OP_DIV_CX: begin
				div_num = (40'(mag_x) << 1) + 40'(sum_q);
				div_den = 25'({sum_q, 1'b0});
				div_neg = tx_q[32];
			end
			OP_DIV_CY: begin
				div_num = (40'(mag_y) << 1) + 40'(sum_q);
				div_den = 25'({sum_q, 1'b0});
				div_neg = ty_q[32];
			end
			OP_DIV_SEV: begin
				div_num = sevn_q;
				div_den = sevd_q;
			end
			OP_DIV_EFF: begin
				div_num = effn_q;
				div_den = effd_q;
			end
			default: ;
		endcase
	end

	// restoring divider, one quotient bit per cycle
	logic [24:0] rem_q, dvs_q;
	logic [15:0] nlo_q, quo_q;
	logic dneg_q;
	logic [25:0] dv_trial, dv_diff;
	logic dv_ge;
	logic signed [16:0] quo_signed;

	assign dv_trial = {rem_q, nlo_q[15]};
	assign dv_diff = dv_trial - {1'b0, dvs_q};
	assign dv_ge = dv_trial >= {1'b0, dvs_q};
	assign quo_signed = dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	// filter weights
	logic [16:0] al, bl;
	assign al = (alpha_q > 16'd32768) ? 17'd32768 : {1'b0, alpha_q};
	assign bl = 17'd32768 - al;

	function automatic logic signed [15:0] round_q15(logic signed [34:0] s);
		logic [34:0] m;
		logic [34:0] q;
		m = s[34] ? 35'(-s) : 35'(s);
		q = (m + 35'd16384) >> 15;
		return s[34] ? 16'(-q) : 16'(q);
	endfunction

	logic signed [15:0] cx_q, cy_q, fx_q, fy_q;
	logic fvalid_q;
	logic signed [33:0] pax_s1, pbx_s1, pay_s1, pby_s1;
	logic signed [31:0] sqx_s1, sqy_s1;

	// square root state
	logic [31:0] sx_q, sr_q, sbit_q, srb;
	assign srb = sr_q + sbit_q;

	// penalty segments
	logic [15:0] off_q, sev_q, eff_q;
	logic in_mild, in_mod;
	logic [15:0] seg_d, seg_n;
	logic [39:0] sev_base, eff_base;

	assign in_mild = (off_q > ok_q) && (off_q <= mild_q);
	assign in_mod = (off_q > ok_q) && !in_mild && (off_q <= moderate_q);
	assign seg_d = in_mild ? (mild_q - ok_q) : (moderate_q - mild_q);
	assign seg_n = in_mild ? (off_q - ok_q) : (off_q - mild_q);
	assign sev_base = in_mild ? (40'(seg_d) + (40'(seg_n) << 1))
		: (40'(seg_d) * 40'd3 + (40'(seg_n) << 2));
	assign eff_base = in_mild ? (40'(seg_d) * 40'd95 - 40'(seg_n) * 40'd10)
		: (40'(seg_d) * 40'd85 - 40'(seg_n) * 40'd35);

	// hysteresis
	logic signed [16:0] fxe, fye;
	logic [16:0] ax, ay;
	logic beyond, below_exit;
	logic latch_q, latch_n;
	prompt_t held_q, held_n;

	assign fxe = 17'(fx_q);
	assign fye = 17'(fy_q);
	assign ax = fxe[16] ? 17'(-fxe) : 17'(fxe);
	assign ay = fye[16] ? 17'(-fye) : 17'(fye);
	assign beyond = (ax > 17'(enter_q)) || (ay > 17'(enter_q));
	assign below_exit = (ax < 17'(exit_q)) && (ay < 17'(exit_q));

	always_comb begin
		latch_n = latch_q;
		held_n = held_q;
		if (!latch_q) begin
			if (beyond) begin
				latch_n = 1'b1;
				held_n = direction(fx_q, fy_q, enter_q);
			end else begin
				held_n = PR_OK;
			end
		end else if (below_exit) begin
			latch_n = 1'b0;
			held_n = PR_OK;
		end else if (beyond) begin
			held_n = direction(fx_q, fy_q, enter_q);
		end
	end

	// result register
	logic out_valid_q;
	logic [17:0] o_total_q;
	logic signed [15:0] o_cx_q, o_cy_q, o_fx_q, o_fy_q;
	logic [15:0] o_off_q, o_sev_q, o_eff_q;
	logic [3:0] o_prompt_q;
	logic o_corr_q;

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= 1'b0;
			latch_q <= 1'b0;
			held_q <= PR_OK;
			fx_q <= '0;
			fy_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_FILT_ADD: begin
					fx_q <= fvalid_q ? round_q15(35'(pax_s1) + 35'(pbx_s1)) : cx_q;
					fy_q <= fvalid_q ? round_q15(35'(pay_s1) + 35'(pby_s1)) : cy_q;
					fvalid_q <= 1'b1;
				end
				OP_COMMIT: begin
					latch_q <= latch_n;
					held_q <= held_n;
					out_valid_q <= 1'b1;
				end
				OP_COMMIT_ZERO: begin
					fvalid_q <= 1'b0;
					latch_q <= 1'b0;
					held_q <= PR_OK;
					fx_q <= '0;
					fy_q <= '0;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				for (int i = 0; i < 8; i++) samp_q[i] <= qual[i];
				sum_q <= '0;
				tx_q <= '0;
				ty_q <= '0;
			end
			OP_ACC: begin
				sum_q <= sum_q + 18'(acc_a);
				tx_q <= tx_q + 33'(acc_px);
				ty_q <= ty_q + 33'(acc_py);
			end
			OP_DIV_CX, OP_DIV_CY, OP_DIV_SEV, OP_DIV_EFF: begin
				rem_q <= {1'b0, div_num[39:16]};
				nlo_q <= div_num[15:0];
				dvs_q <= div_den;
				dneg_q <= div_neg;
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= dv_ge ? dv_diff[24:0] : dv_trial[24:0];
				nlo_q <= {nlo_q[14:0], 1'b0};
				quo_q <= {quo_q[14:0], dv_ge};
			end
			OP_SAVE_CX: cx_q <= quo_signed[15:0];
			OP_SAVE_CY: cy_q <= quo_signed[15:0];
			OP_FILT_MUL: begin
				pax_s1 <= $signed({1'b0, al}) * cx_q;
				pbx_s1 <= $signed({1'b0, bl}) * fx_q;
				pay_s1 <= $signed({1'b0, al}) * cy_q;
				pby_s1 <= $signed({1'b0, bl}) * fy_q;
			end
			OP_SQ_MUL: begin
				sqx_s1 <= fx_q * fx_q;
				sqy_s1 <= fy_q * fy_q;
			end
			OP_SQRT_INIT: begin
				sx_q <= 32'(sqx_s1) + 32'(sqy_s1);
				sr_q <= '0;
				sbit_q <= 32'h4000_0000;
			end
			OP_SQRT_STEP: begin
				if (sx_q >= srb) begin
					sx_q <= sx_q - srb;
					sr_q <= (sr_q >> 1) + sbit_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_ROUND: off_q <= 16'(sr_q + 32'(sx_q > sr_q));
			OP_SEG: begin
				sevn_q <= (sev_base << 16) + 40'(seg_d) * 40'd10;
				sevd_q <= 25'(seg_d) * 25'd20;
				effn_q <= (eff_base << 16) + 40'(seg_d) * 40'd100;
				effd_q <= 25'(seg_d) * 25'd200;
				if (off_q <= ok_q) begin
					sev_q <= 16'd0;
					eff_q <= 16'd32768;
				end else begin
					sev_q <= 16'd32768;
					eff_q <= 16'd0;
				end
			end
			OP_SAVE_SEV: sev_q <= quo_q;
			OP_SAVE_EFF: eff_q <= quo_q;
			OP_COMMIT: begin
				o_total_q <= sum_q;
				o_cx_q <= cx_q;
				o_cy_q <= cy_q;
				o_fx_q <= fx_q;
				o_fy_q <= fy_q;
				o_off_q <= off_q;
				o_sev_q <= sev_q;
				o_eff_q <= eff_q;
				o_prompt_q <= held_n;
				o_corr_q <= latch_n;
			end
			OP_COMMIT_ZERO: begin
				o_total_q <= '0;
				o_cx_q <= '0;
				o_cy_q <= '0;
				o_fx_q <= '0;
				o_fy_q <= '0;
				o_off_q <= '0;
				o_sev_q <= '0;
				o_eff_q <= 16'd32768;
				o_prompt_q <= PR_OK;
				o_corr_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// status: zero sum, segment divide needed (taken from the offset held since the rounding step), output free
	assign status.sum_zero = (sum_q == 18'd0);
	assign status.seg_div = in_mild || in_mod;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign total_activity = o_total_q;
	assign raw_x = o_cx_q;
	assign raw_y = o_cy_q;
	assign filtered_x = o_fx_q;
	assign filtered_y = o_fy_q;
	assign offset = o_off_q;
	assign severity = o_sev_q;
	assign effectiveness = o_eff_q;
	assign prompt = o_prompt_q;
	assign correcting = o_corr_q;

endmodule
`default_nettype wire

// File: hdl/pressure_centroid_placement_guide_core.sv
// paths: the zero result when no sensor is active, the full result without a segment divide
// when the offset needs none, and the full result with severity and effectiveness divides
// transactions: one at a time, next input taken in the idle state after the result is
// loaded, once the output is free; the 16-step shared divider (up to four passes) and the
// 16-step square root are the iterative steps of the sequence
// reset: arst_n clears config to defaults, filter and hysteresis state, and output valid
`default_nettype none
module pressure_centroid_placement_guide_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sensor_0,
	input  logic signed [15:0] sensor_1,
	input  logic signed [15:0] sensor_2,
	input  logic signed [15:0] sensor_3,
	input  logic signed [15:0] sensor_4,
	input  logic signed [15:0] sensor_5,
	input  logic signed [15:0] sensor_6,
	input  logic signed [15:0] sensor_7,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [17:0]        total_activity,
	output logic signed [15:0] raw_x,
	output logic signed [15:0] raw_y,
	output logic signed [15:0] filtered_x,
	output logic signed [15:0] filtered_y,
	output logic [15:0]        offset,
	output logic [15:0]        severity,
	output logic [15:0]        effectiveness,
	output logic [3:0]         prompt,
	output logic               correcting,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import pcpg_pkg::*;

	cmd_t cmd;
	status_t status;

	// sequencer
	pcpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	// arithmetic and result register
	pcpg_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sensor_0       (sensor_0),
		.sensor_1       (sensor_1),
		.sensor_2       (sensor_2),
		.sensor_3       (sensor_3),
		.sensor_4       (sensor_4),
		.sensor_5       (sensor_5),
		.sensor_6       (sensor_6),
		.sensor_7       (sensor_7),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.total_activity (total_activity),
		.raw_x          (raw_x),
		.raw_y          (raw_y),
		.filtered_x     (filtered_x),
		.filtered_y     (filtered_y),
		.offset         (offset),
		.severity       (severity),
		.effectiveness  (effectiveness),
		.prompt         (prompt),
		.correcting     (correcting)
	);

`ifndef NO_ASSERTIONS
	// a transaction is worked on alone
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// prompt is only non-ok while correcting
	a_prompt_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !correcting |-> prompt == PR_OK)
		else $error("prompt set without correcting latch");

	// no activity gives the idle result
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_activity == 18'd0 |->
		effectiveness == 16'd32768 && severity == 16'd0 && offset == 16'd0)
		else $error("bad result for zero activity");

	// zero severity only comes from the ok segment
	a_sev_eff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && severity == 16'd0 |-> effectiveness == 16'd32768)
		else $error("severity and effectiveness disagree");
`endif

endmodule
`default_nettype wire
